// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ===== hw/rtl/dfr_pkg.sv =====
// types and constants of the length prefixed frame deframer
`default_nettype none

package dfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int POS_W       = 17;
  localparam int KIND_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BODY     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GOOD     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAIL_ERR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_PATTERN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_VALUE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH    = 3'd3;

  // frame positions
  localparam logic [POS_W-1:0] POS_LEN_LO     = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_HI     = 17'd5;
  localparam logic [POS_W-1:0] POS_BODY_START = 17'd6;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd1024;
  localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 16'd1;

  typedef struct packed {
    logic [31:0]       start_pattern;
    logic [BYTE_W-1:0] tail_value;
    logic [LEN_W-1:0]  max_length;
    logic [LEN_W-1:0]  min_length;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  body_index;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfr_cfg.sv =====
// configuration register file of the deframer
`default_nettype none

module dfr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dfr_pkg::cfg_t                        cfg
);
  import dfr_pkg::*;

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pattern <= '0;
      cfg.tail_value    <= '0;
      cfg.max_length    <= MAX_LENGTH_RESET;
      cfg.min_length    <= MIN_LENGTH_RESET;
    end else if (wr) begin
      case (cfg_index)
        REG_START_PATTERN: cfg.start_pattern <= cfg_data;
        REG_TAIL_VALUE:    cfg.tail_value    <= cfg_data[BYTE_W-1:0];
        REG_MAX_LENGTH:    cfg.max_length    <= cfg_data[LEN_W-1:0];
        REG_MIN_LENGTH:    cfg.min_length    <= cfg_data[LEN_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dfr_parse.sv =====
// frame position tracking and per byte classification
`include "assert_macros.svh"
`default_nettype none

module dfr_parse (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [dfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire dfr_pkg::cfg_t              cfg,
  output dfr_pkg::result_t                result
);
  import dfr_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [LEN_W-1:0]  frame_length;
  logic [LEN_W-1:0]  frame_length_next;
  logic [BYTE_W-1:0] want;
  logic [LEN_W-1:0]  full_len;
  logic [LEN_W-1:0]  body_len;
  logic [POS_W-1:0]  tail_pos;
  logic [POS_W-1:0]  body_off;

  assign want     = cfg.start_pattern[{pos[1:0], 3'b000} +: BYTE_W];
  assign full_len = {rx_byte, frame_length[BYTE_W-1:0]};
  // zero length means empty body
  assign body_len = (frame_length == '0) ? '0 : frame_length - LEN_W'(1);
  assign tail_pos = POS_BODY_START + {1'b0, body_len};
  assign body_off = pos - POS_BODY_START;

  always_comb begin
    pos_next          = pos;
    frame_length_next = frame_length;
    result.data_byte  = rx_byte;
    result.kind       = KIND_HEADER;
    result.body_index = '0;
    if (pos < POS_LEN_LO) begin
      // mismatch restarts the hunt without re-examining this byte
      pos_next = (rx_byte == want) ? pos + POS_W'(1) : '0;
    end else if (pos == POS_LEN_LO) begin
      frame_length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
      pos_next          = POS_LEN_HI;
    end else if (pos == POS_LEN_HI) begin
      frame_length_next = full_len;
      if (full_len < cfg.min_length || full_len > cfg.max_length) begin
        result.kind = KIND_REJECT;
        pos_next    = '0;
      end else begin
        pos_next = POS_BODY_START;
      end
    end else if (pos >= tail_pos) begin
      result.kind = (rx_byte == cfg.tail_value) ? KIND_GOOD : KIND_TAIL_ERR;
      pos_next    = '0;
    end else begin
      result.kind       = KIND_BODY;
      result.body_index = body_off[LEN_W-1:0];
      pos_next          = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      frame_length <= '0;
    end else if (step) begin
      pos          <= pos_next;
      frame_length <= frame_length_next;
    end
  end

  `ASSERT_NEVER(a_index_only_on_body, clk, rst, step && result.kind != KIND_BODY && result.body_index != '0, "body index set outside body")
  `ASSERT_PROP(a_restart_after_end, clk, rst, step && (result.kind == KIND_GOOD || result.kind == KIND_TAIL_ERR || result.kind == KIND_REJECT) |=> pos == '0, "hunt not restarted")
  `ASSERT_PROP(a_body_advances, clk, rst, step && result.kind == KIND_BODY |=> pos == $past(pos) + POS_W'(1), "body position did not advance")

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_deframer_top.sv =====
// top level of the length prefixed frame deframer
//
//   port group  direction  handshake              carries
//   in          to block   in_valid / in_stall    rx_byte
//   out         from block out_valid / out_stall  data_byte, kind, body_index
//   cfg         to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; each item passes through the input
// register and then the result register around the parser
// out_stall reaches in_stall combinationally, gated by the valid bits of the two register stages
// synchronous reset clears state and config at once, no clearing pass
`include "assert_macros.svh"
`default_nettype none

module length_prefixed_frame_deframer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [dfr_pkg::BYTE_W-1:0]      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [dfr_pkg::BYTE_W-1:0]           data_byte,
  output logic [dfr_pkg::KIND_W-1:0]           kind,
  output logic [dfr_pkg::LEN_W-1:0]            body_index,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dfr_pkg::*;

  cfg_t              cfg;
  result_t           result;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  dfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfr_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      data_byte  <= result.data_byte;
      kind       <= result.kind;
      body_index <= result.body_index;
    end
  end

  `ASSERT_NEVER(a_stall_needs_item, clk, rst, in_stall && !s1_valid, "stall with empty input register")
  `ASSERT_PROP(a_item_moves_out, clk, rst, s1_valid && !out_valid |=> out_valid, "item not moved to result register")
  `ASSERT_PROP(a_result_not_lost, clk, rst, !$past(rst) && $fell(out_valid) |-> $past(!out_stall), "result dropped while stalled")

endmodule

`default_nettype wire
